/* sv/session_token_table_core_assert.svh */
// assertion macros for the session token table checker
// no dependencies; taken in by the checker with `include
`ifndef SESSION_TOKEN_TABLE_CORE_ASSERT_SVH
`define SESSION_TOKEN_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("session token table check failed");

// next-cycle implication
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("session token table check failed");

`endif

/* sv/stt_pkg.sv */
// shared types and constants for the session token table
// no dependencies; used by stt_alu and session_token_table_core
package stt_pkg;

   localparam int TOKEN_W = 256;
   localparam int EXP_W   = 63;
   localparam int TTL_W   = 48;

   localparam logic [TTL_W-1:0] TTL_RESET = 48'd43200000000;
   localparam logic [EXP_W-1:0] EXP_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [1:0] REQ_CREATE   = 2'd0;
   localparam logic [1:0] REQ_VALIDATE = 2'd1;
   localparam logic [1:0] REQ_DESTROY  = 2'd2;
   localparam logic [1:0] REQ_NOP      = 2'd3;

   typedef enum logic [0:0] {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [EXP_W-1:0] a;
      logic [EXP_W-1:0] b;
   } alu_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_READ,
      S_EVAL,
      S_WRITE,
      S_DONE
   } state_type;

endpackage

/* sv/stt_ram.sv */
// generic single write port ram with registered read
// no dependencies; holds slot tokens and expiry times
module stt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/stt_alu.sv */
// shared 63-bit add and subtract unit (64-bit result with carry/borrow) for expiry sums and compares
// depends on stt_pkg
module stt_alu (
   input  stt_pkg::alu_req_type req,
   output logic [stt_pkg::EXP_W:0] res
);

   always_comb begin
      case (req.op)
         stt_pkg::ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
         stt_pkg::ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
         default:          res = '0;
      endcase
   end

endmodule

/* sv/session_token_table_core.sv */
// session token table: sequencer walking the slots through one shared add/sub unit
// depends on stt_pkg, stt_ram and stt_alu
//
//   channel   handshake               payload
//   request   start / busy            req_type, req_token_word0..3, req_now_us
//   result    rsp_strobe (one cycle)  rsp_granted, rsp_hit, rsp_slot_index,
//                                     rsp_replaced, rsp_purged_count
//   csr       csr_wr_en               csr_wr_data (ttl in microseconds)
//
// each slot visited takes a ram read state, then a compare state in the shared unit
// validate and destroy: the scan stops at the first hit or the last slot, then the strobe
// create: an expiry sum state before the scan and a ram write state after it
// unused request code: strobe on the next cycle; busy stays high until the strobe ends
// synchronous reset clears the valid bits and reloads the default ttl; results cannot be stalled
module session_token_table_core #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_token_word0,
   input  logic [63:0] req_token_word1,
   input  logic [63:0] req_token_word2,
   input  logic [63:0] req_token_word3,
   input  logic [62:0] req_now_us,
   output logic        rsp_strobe,
   output logic        rsp_granted,
   output logic        rsp_hit,
   output logic [2:0]  rsp_slot_index,
   output logic        rsp_replaced,
   output logic [3:0]  rsp_purged_count,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   stt_pkg::state_type state_ff, state_in;

   logic [stt_pkg::TTL_W-1:0]   ttl_ff, ttl_in;
   logic [1:0]                  op_ff, op_in;
   logic [stt_pkg::TOKEN_W-1:0] token_ff, token_in;
   logic [stt_pkg::EXP_W-1:0]   now_ff, now_in;
   logic [stt_pkg::EXP_W-1:0]   exp_new_ff, exp_new_in;
   logic [stt_pkg::EXP_W-1:0]   min_ff, min_in;
   logic [SLOT_W-1:0]           cnt_ff, cnt_in;
   logic [SLOT_W-1:0]           target_ff, target_in;
   logic [SLOT_W-1:0]           idx_ff, idx_in;
   logic [SLOTS-1:0]            used_ff, used_in;
   logic                        granted_ff, granted_in;
   logic                        hit_ff, hit_in;
   logic                        replaced_ff, replaced_in;
   logic [3:0]                  purged_ff, purged_in;

   logic                        accept;
   logic                        ram_we;
   logic [stt_pkg::TOKEN_W-1:0] rd_token;
   logic [stt_pkg::EXP_W-1:0]   rd_exp;
   stt_pkg::alu_req_type        alu_req;
   logic [stt_pkg::EXP_W:0]     alu_res;
   logic                        borrow;
   logic                        slot_used;
   logic                        tok_match;
   logic                        last;
   logic                        hit_v;
   logic                        hit_d;

   assign accept    = (state_ff == stt_pkg::S_IDLE) && start;
   assign borrow    = alu_res[stt_pkg::EXP_W];
   assign slot_used = used_ff[cnt_ff];
   assign tok_match = (rd_token == token_ff);
   assign last      = (cnt_ff == LAST_SLOT);
   assign hit_v     = slot_used && borrow && tok_match;
   assign hit_d     = slot_used && tok_match;

   stt_ram #(
      .WIDTH (stt_pkg::TOKEN_W),
      .DEPTH (SLOTS)
   ) u_token_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (target_ff),
      .wr_data (token_ff),
      .rd_addr (cnt_ff),
      .rd_data (rd_token)
   );

   stt_ram #(
      .WIDTH (stt_pkg::EXP_W),
      .DEPTH (SLOTS)
   ) u_expiry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (target_ff),
      .wr_data (exp_new_ff),
      .rd_addr (cnt_ff),
      .rd_data (rd_exp)
   );

   stt_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stt_pkg::S_IDLE: begin
            if (start) begin
               case (req_type)
                  stt_pkg::REQ_CREATE: state_in = stt_pkg::S_SUM;
                  stt_pkg::REQ_NOP:    state_in = stt_pkg::S_DONE;
                  default:             state_in = stt_pkg::S_READ;
               endcase
            end
         end
         stt_pkg::S_SUM:  state_in = stt_pkg::S_READ;
         stt_pkg::S_READ: state_in = stt_pkg::S_EVAL;
         stt_pkg::S_EVAL: begin
            state_in = stt_pkg::S_READ;
            case (op_ff)
               stt_pkg::REQ_CREATE: begin
                  if (!slot_used || last) begin
                     state_in = stt_pkg::S_WRITE;
                  end
               end
               stt_pkg::REQ_VALIDATE: begin
                  if (hit_v || last) begin
                     state_in = stt_pkg::S_DONE;
                  end
               end
               stt_pkg::REQ_DESTROY: begin
                  if (hit_d || last) begin
                     state_in = stt_pkg::S_DONE;
                  end
               end
               default: state_in = stt_pkg::S_DONE;
            endcase
         end
         stt_pkg::S_WRITE: state_in = stt_pkg::S_DONE;
         stt_pkg::S_DONE:  state_in = stt_pkg::S_IDLE;
         default:          state_in = stt_pkg::S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      ram_we     = 1'b0;
      alu_req.op = stt_pkg::ALU_SUB;
      alu_req.a  = now_ff;
      alu_req.b  = rd_exp;
      case (state_ff)
         stt_pkg::S_IDLE: busy = 1'b0;
         stt_pkg::S_SUM: begin
            alu_req.op = stt_pkg::ALU_ADD;
            alu_req.b  = stt_pkg::EXP_W'(ttl_ff);
         end
         stt_pkg::S_EVAL: begin
            if (op_ff == stt_pkg::REQ_CREATE) begin
               alu_req.a = rd_exp;
               alu_req.b = min_ff;
            end
         end
         stt_pkg::S_WRITE: ram_we = 1'b1;
         stt_pkg::S_DONE:  rsp_strobe = 1'b1;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      ttl_in      = ttl_ff;
      op_in       = op_ff;
      token_in    = token_ff;
      now_in      = now_ff;
      exp_new_in  = exp_new_ff;
      min_in      = min_ff;
      cnt_in      = cnt_ff;
      target_in   = target_ff;
      idx_in      = idx_ff;
      used_in     = used_ff;
      granted_in  = granted_ff;
      hit_in      = hit_ff;
      replaced_in = replaced_ff;
      purged_in   = purged_ff;

      if (csr_wr_en) begin
         ttl_in = csr_wr_data;
      end

      case (state_ff)
         stt_pkg::S_IDLE: begin
            if (accept) begin
               op_in       = req_type;
               token_in    = {req_token_word3, req_token_word2,
                              req_token_word1, req_token_word0};
               now_in      = req_now_us;
               cnt_in      = '0;
               target_in   = '0;
               idx_in      = '0;
               granted_in  = 1'b0;
               hit_in      = 1'b0;
               replaced_in = 1'b0;
               purged_in   = '0;
            end
         end
         stt_pkg::S_SUM: begin
            exp_new_in = borrow ? stt_pkg::EXP_MAX : alu_res[stt_pkg::EXP_W-1:0];
         end
         stt_pkg::S_EVAL: begin
            cnt_in = cnt_ff + 1'b1;
            case (op_ff)
               stt_pkg::REQ_CREATE: begin
                  if (!slot_used) begin
                     target_in = cnt_ff;
                  end else begin
                     if ((cnt_ff == '0) || borrow) begin
                        min_in    = rd_exp;
                        target_in = cnt_ff;
                     end
                     if (last) begin
                        replaced_in = 1'b1;
                     end
                  end
               end
               stt_pkg::REQ_VALIDATE: begin
                  if (slot_used) begin
                     if (!borrow) begin
                        used_in[cnt_ff] = 1'b0;
                        purged_in       = purged_ff + 4'd1;
                     end else if (tok_match) begin
                        granted_in = 1'b1;
                        hit_in     = 1'b1;
                        idx_in     = cnt_ff;
                     end
                  end
               end
               stt_pkg::REQ_DESTROY: begin
                  if (hit_d) begin
                     used_in[cnt_ff] = 1'b0;
                     hit_in          = 1'b1;
                     idx_in          = cnt_ff;
                  end
               end
               default: ;
            endcase
         end
         stt_pkg::S_WRITE: begin
            used_in[target_ff] = 1'b1;
            hit_in             = 1'b1;
            idx_in             = target_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::S_IDLE;
         ttl_ff   <= stt_pkg::TTL_RESET;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ttl_ff   <= ttl_in;
         used_ff  <= used_in;
      end
      op_ff       <= op_in;
      token_ff    <= token_in;
      now_ff      <= now_in;
      exp_new_ff  <= exp_new_in;
      min_ff      <= min_in;
      cnt_ff      <= cnt_in;
      target_ff   <= target_in;
      idx_ff      <= idx_in;
      granted_ff  <= granted_in;
      hit_ff      <= hit_in;
      replaced_ff <= replaced_in;
      purged_ff   <= purged_in;
   end

   assign rsp_granted      = granted_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_slot_index   = 3'(idx_ff);
   assign rsp_replaced     = replaced_ff;
   assign rsp_purged_count = purged_ff;

endmodule

/* sv/stt_checker.sv */
// port-level checks for the session token table, bound to the top level
// depends on session_token_table_core_assert.svh
`include "session_token_table_core_assert.svh"

module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_granted,
   input logic        rsp_hit,
   input logic [2:0]  rsp_slot_index,
   input logic        rsp_replaced,
   input logic [3:0]  rsp_purged_count
);

   // a transfer keeps the block busy until its result
   `STT_ASSERT_NEXT(a_busy_after_transfer, clock, reset, start && !busy, busy)
   // the result cycle is the last busy one
   `STT_ASSERT_NEXT(a_idle_after_result, clock, reset, rsp_strobe, !busy && !rsp_strobe)
   // a miss reports slot zero and no grant
   `STT_ASSERT_IMPLY(a_miss_fields, clock, reset, rsp_strobe && !rsp_hit,
                     (rsp_slot_index == 3'd0) && !rsp_granted && !rsp_replaced)
   // a grant comes only from validate, which never replaces
   `STT_ASSERT_IMPLY(a_grant_fields, clock, reset, rsp_strobe && rsp_granted,
                     rsp_hit && !rsp_replaced)
   // only validate purges, so a replacing create reports none
   `STT_ASSERT_IMPLY(a_purge_fields, clock, reset, rsp_strobe && rsp_replaced,
                     rsp_purged_count == 4'd0)

endmodule

bind session_token_table_core stt_checker u_stt_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_granted      (rsp_granted),
   .rsp_hit          (rsp_hit),
   .rsp_slot_index   (rsp_slot_index),
   .rsp_replaced     (rsp_replaced),
   .rsp_purged_count (rsp_purged_count)
);
